FILE: design/accel_shake_detector_core_macros.svh
// Assertion macros for the shake detector checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ACCEL_SHAKE_DETECTOR_CORE_MACROS_SVH
`define ACCEL_SHAKE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ASD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants for the accelerometer shake detector.
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

    // Axis and field sizes
    localparam int AXES_MAX   = 3;
    localparam int DIR_W      = 2 * AXES_MAX;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 12;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register defaults after reset
    localparam logic [THR_W-1:0] THR_RESET       = 12'd1;
    localparam logic [MS_W-1:0]  HYST_RESET      = 16'd100;
    localparam logic [MS_W-1:0]  MIN_SHAKE_RESET = 16'd500;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_HYSTERESIS = 2'd1,
        CFG_MIN_SHAKE  = 2'd2
    } cfg_reg_t;

    // Evaluate beat handed from the lanes to the merge stage
    typedef struct packed {
        logic [DIR_W-1:0]  dir;
        logic [TIME_W-1:0] now_ms;
    } eval_beat_t;

    // Timing settings seen by the merge stage
    typedef struct packed {
        logic [MS_W-1:0] hysteresis_ms;
        logic [MS_W-1:0] min_shake_ms;
    } gesture_cfg_t;

    // One result beat
    typedef struct packed {
        logic [DIR_W-1:0] direction_bits;
        logic             moving;
        logic             shake;
    } result_t;

endpackage

`default_nettype wire

FILE: design/asd_in_if.sv
// ----------------------------------------------------------------------------
// asd_in_if
// Input item channel: sample or evaluate beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface asd_in_if #(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic [SAMPLE_BITS-1:0] z_sample;
    logic [31:0]            now_ms;

    modport source (output valid, mode, x_sample, y_sample, z_sample, now_ms,
                    input ready);
    modport sink   (input valid, mode, x_sample, y_sample, z_sample, now_ms,
                    output ready);
endinterface

`default_nettype wire

FILE: design/asd_out_if.sv
// ----------------------------------------------------------------------------
// asd_out_if
// Result channel: direction bits, moving flag and shake report.
// ----------------------------------------------------------------------------
`default_nettype none

interface asd_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] direction_bits;
    logic       moving;
    logic       shake;

    modport source (output valid, direction_bits, moving, shake, input ready);
    modport sink   (input valid, direction_bits, moving, shake, output ready);
endinterface

`default_nettype wire

FILE: design/asd_cfg_if.sv
// ----------------------------------------------------------------------------
// asd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface asd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: design/asd_axis_lane.sv
// ----------------------------------------------------------------------------
// asd_axis_lane
// One axis: previous reading, saturating delta sum and threshold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_axis_lane
    import asd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_en,
    input  wire logic                   eval_en,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [THR_W-1:0]       threshold,
    output logic                        dir_pos,
    output logic                        dir_neg
);

    localparam int SUM_W = SAMPLE_BITS + 1;
    localparam int CMP_W = ((SUM_W > THR_W + 1) ? SUM_W : THR_W + 1) + 1;

    logic [SAMPLE_BITS-1:0]  last_reg, last_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [SUM_W:0]          acc;
    logic signed [CMP_W-1:0] sum_x;
    logic signed [CMP_W-1:0] thr_x;
    logic signed [CMP_W-1:0] thr_neg;

    // sum + (last - new), one guard bit, then saturate
    always_comb
    begin
        acc = {sum_reg[SUM_W-1], sum_reg} + {2'b00, last_reg} - {2'b00, sample};
        last_next = last_reg;
        sum_next  = sum_reg;
        if (sample_en)
        begin
            last_next = sample;
            if (acc[SUM_W] != acc[SUM_W-1])
            begin
                sum_next = acc[SUM_W] ? {1'b1, {SAMPLE_BITS{1'b0}}}
                                      : {1'b0, {SAMPLE_BITS{1'b1}}};
            end
            else
            begin
                sum_next = acc[SUM_W-1:0];
            end
        end
        else if (eval_en)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            last_reg <= last_next;
            sum_reg  <= sum_next;
        end
    end

    // classify the current sum against +/- threshold
    always_comb
    begin
        sum_x   = {{(CMP_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
        thr_x   = {{(CMP_W-THR_W){1'b0}}, threshold};
        thr_neg = -thr_x;
        dir_pos = (sum_x > thr_x);
        dir_neg = (sum_x < thr_neg);
    end

endmodule

`default_nettype wire

FILE: design/asd_gesture.sv
// ----------------------------------------------------------------------------
// asd_gesture
// Merge stage: folds the lane direction bits into move and shake tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_gesture
    import asd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire eval_beat_t   beat,
    input  wire gesture_cfg_t cfg,
    output result_t           res
);

    logic              active_reg, active_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] end_reg, end_next;

    logic              motion;
    logic              starts;
    logic              ends;
    logic              pending_mid;
    logic              shake;
    logic [TIME_W-1:0] hyst_deadline;
    logic [TIME_W-1:0] dur;

    always_comb
    begin
        motion        = |beat.dir;
        hyst_deadline = start_reg + {{(TIME_W-MS_W){1'b0}}, cfg.hysteresis_ms};
        starts        = motion && !active_reg;
        ends          = !motion && active_reg && (hyst_deadline < beat.now_ms);

        active_next = active_reg;
        if (starts)
        begin
            active_next = 1'b1;
        end
        else if (ends)
        begin
            active_next = 1'b0;
        end

        start_next  = starts ? beat.now_ms : start_reg;
        end_next    = ends ? beat.now_ms : end_reg;
        pending_mid = pending_reg || ends;

        // a move ending now lasts now - start; otherwise the stored span
        dur   = ends ? (beat.now_ms - start_reg) : (end_reg - start_reg);
        shake = pending_mid && !active_next &&
                (dur > {{(TIME_W-MS_W){1'b0}}, cfg.min_shake_ms});
        pending_next = pending_mid && !shake;

        res.direction_bits = beat.dir;
        res.moving         = active_next;
        res.shake          = shake;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pending_reg <= 1'b0;
            start_reg   <= '0;
            end_reg     <= '0;
        end
        else if (advance)
        begin
            active_reg  <= active_next;
            pending_reg <= pending_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/accel_shake_detector_core.sv
// Evaluate items: lane classify into stage 1, then merge into the output register.
// Sample items: absorbed into the lane registers, no result beat.
// Throughput: one item per cycle, unless the output stalls and input ready drops.
// Input ready drops only while stage 1 and the output are full and not being taken.
// Reset (rst_n, async, active low): clears lane sums, move state, pipeline valids,
// and loads the configuration defaults (threshold 1, hysteresis 100, min shake 500).
// ----------------------------------------------------------------------------
// accel_shake_detector_core
// Per-axis delta lanes feeding a move/shake merge stage, with config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_shake_detector_core
    import asd_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int NUM_AXES    = 3
) (
    input  wire logic clk,
    input  wire logic rst_n,
    asd_in_if.sink    item,
    asd_out_if.source result,
    asd_cfg_if.sink   cfg
);

    logic [THR_W-1:0] thr_reg, thr_next;
    logic [MS_W-1:0]  hyst_reg, hyst_next;
    logic [MS_W-1:0]  min_shake_reg, min_shake_next;

    logic             s1_valid_reg, s1_valid_next;
    eval_beat_t       s1_beat_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;

    logic             item_take;
    logic             sample_take;
    logic             eval_take;
    logic             out_free;
    logic             s1_adv;
    logic [DIR_W-1:0] lane_dir;
    gesture_cfg_t     g_cfg;
    result_t          g_res;

    logic [SAMPLE_BITS-1:0] samples [AXES_MAX];

    // ---------------- configuration registers ----------------
    assign cfg.ready = 1'b1;

    always_comb
    begin
        thr_next       = thr_reg;
        hyst_next      = hyst_reg;
        min_shake_next = min_shake_reg;
        if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.reg_index))
                CFG_THRESHOLD:  thr_next       = cfg.wdata[THR_W-1:0];
                CFG_HYSTERESIS: hyst_next      = cfg.wdata[MS_W-1:0];
                CFG_MIN_SHAKE:  min_shake_next = cfg.wdata[MS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= THR_RESET;
            hyst_reg      <= HYST_RESET;
            min_shake_reg <= MIN_SHAKE_RESET;
        end
        else
        begin
            thr_reg       <= thr_next;
            hyst_reg      <= hyst_next;
            min_shake_reg <= min_shake_next;
        end
    end

    // ---------------- handshake and pipeline flow ----------------
    assign out_free    = !out_valid_reg || result.ready;
    assign s1_adv      = s1_valid_reg && out_free;
    assign item.ready  = !s1_valid_reg || out_free;
    assign item_take   = item.valid && item.ready;
    assign sample_take = item_take && !item.mode;
    assign eval_take   = item_take && item.mode;

    // ---------------- axis lanes ----------------
    assign samples[0] = item.x_sample;
    assign samples[1] = item.y_sample;
    assign samples[2] = item.z_sample;

    for (genvar a = 0; a < AXES_MAX; a++)
    begin : g_lane
        if (a < NUM_AXES)
        begin : g_used
            asd_axis_lane #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .sample_en (sample_take),
                .eval_en   (eval_take),
                .sample    (samples[a]),
                .threshold (thr_reg),
                .dir_pos   (lane_dir[2*a]),
                .dir_neg   (lane_dir[2*a+1])
            );
        end
        else
        begin : g_unused
            assign lane_dir[2*a]   = 1'b0;
            assign lane_dir[2*a+1] = 1'b0;
        end
    end

    // ---------------- stage 1: classified evaluate beat ----------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (eval_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_take)
        begin
            s1_beat_reg.dir    <= lane_dir;
            s1_beat_reg.now_ms <= item.now_ms;
        end
    end

    // ---------------- stage 2: merge ----------------
    assign g_cfg.hysteresis_ms = hyst_reg;
    assign g_cfg.min_shake_ms  = min_shake_reg;

    asd_gesture u_gesture (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_adv),
        .beat    (s1_beat_reg),
        .cfg     (g_cfg),
        .res     (g_res)
    );

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_res_reg <= g_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.direction_bits = out_res_reg.direction_bits;
    assign result.moving         = out_res_reg.moving;
    assign result.shake          = out_res_reg.shake;

endmodule

`default_nettype wire

FILE: design/asd_checker.sv
// ----------------------------------------------------------------------------
// asd_checker
// Port-level checks on the result channel of the shake detector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_shake_detector_core_macros.svh"

module asd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic [5:0] direction_bits,
    input wire logic       moving,
    input wire logic       shake
);

    // a stalled result beat keeps its payload
    `ASD_ASSERT_NXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable({direction_bits, moving, shake}),
        "result beat changed while stalled")

    // an axis is never both positive and negative
    `ASD_ASSERT_IMP(a_dir_exclusive, result_valid,
        !(direction_bits[0] && direction_bits[1]) &&
        !(direction_bits[2] && direction_bits[3]) &&
        !(direction_bits[4] && direction_bits[5]),
        "both directions flagged on one axis")

    // any motion leaves a move active
    `ASD_ASSERT_IMP(a_motion_moving, result_valid && (direction_bits != 6'd0),
        moving, "motion seen but no move active")

    // a shake is only reported once the move has ended
    `ASD_ASSERT_IMP(a_shake_still, result_valid && shake,
        !moving && (direction_bits == 6'd0), "shake reported during a move")

endmodule

bind accel_shake_detector_core asd_checker u_asd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .direction_bits (result.direction_bits),
    .moving         (result.moving),
    .shake          (result.shake)
);

`default_nettype wire
